@@ src/zsps_pkg.sv @@
// Package for the zero suppression and pedestal subtraction block.
// Holds payload types, opcodes, field widths and constants; depends on nothing.
`default_nettype none

package zsps_pkg;

   // Default configuration of the table geometry and pedestal format.
   localparam int CHANNELS_DEF      = 4800;
   localparam int CAPS_DEF          = 128;
   localparam int BOARDS_DEF        = 6;
   localparam int PED_FRAC_BITS_DEF = 4;

   // Fixed field widths.
   localparam int OP_W       = 2;
   localparam int BOARD_W    = 3;
   localparam int CAP_WORD_W = 16;
   localparam int CAP_SEL_W  = 7;
   localparam int CHAN_W     = 13;
   localparam int ADC_W      = 16;
   localparam int PED_W      = 20;
   localparam int THR_W      = 16;
   localparam int RAW_W      = 20;
   localparam int SECTOR_W   = 4;
   localparam int FIBER_W    = 6;
   localparam int HITS_W     = 13;
   localparam int SUM_OUT_W  = 32;
   localparam int OBYTES_W   = 15;
   localparam int ENTRY_W    = PED_W + THR_W;

   // Signed accumulator in pedestal units, and rounded pedestal width.
   localparam int SUM_W   = 40;
   localparam int PED_R_W = PED_W + 1;

   localparam logic [SECTOR_W-1:0]  SECTOR_RESET   = 4'd1;
   localparam logic [FIBER_W-1:0]   FIBER_OFFSET   = 6'd2;
   localparam logic [HITS_W-1:0]    HITS_MAX       = 13'h1FFF;
   localparam logic [OBYTES_W:0]    OBYTES_BASE    = 16'd8;
   localparam logic [OBYTES_W:0]    OBYTES_MAX     = 16'd32767;
   localparam logic [SUM_OUT_W-1:0] ADC_SUM_MAX    = 32'hFFFF_FFFF;

   localparam logic KIND_HIT     = 1'b0;
   localparam logic KIND_SUMMARY = 1'b1;

   typedef enum logic [OP_W-1:0] {
      OP_LOAD   = 2'd0,
      OP_START  = 2'd1,
      OP_SAMPLE = 2'd2,
      OP_END    = 2'd3
   } op_type;

   typedef struct packed {
      op_type                op;
      logic [BOARD_W-1:0]    board;
      logic [CAP_WORD_W-1:0] cap_word;
      logic [CHAN_W-1:0]     chan;
      logic [ADC_W-1:0]      adc;
      logic [PED_W-1:0]      ped_fixed;
      logic [THR_W-1:0]      threshold;
      logic [RAW_W-1:0]      raw_bytes;
   } req_payload_type;

   typedef struct packed {
      logic                  kind;
      logic [CHAN_W-1:0]     hit_chan;
      logic [ADC_W-1:0]      hit_value;
      logic [CAP_WORD_W-1:0] event_cap_word;
      logic [FIBER_W-1:0]    fiber;
      logic [HITS_W-1:0]     hit_count;
      logic [SUM_OUT_W-1:0]  adc_sum;
      logic [OBYTES_W-1:0]   sparse_bytes;
      logic                  oversize;
   } rsp_payload_type;

   // One table entry: pedestal and threshold.
   typedef struct packed {
      logic [PED_W-1:0] ped;
      logic [THR_W-1:0] thr;
   } entry_type;

   // Item held between the front stage and the back stage.
   typedef struct packed {
      logic              valid;
      op_type            op;
      logic              ok;
      logic [CHAN_W-1:0] chan;
      logic [ADC_W-1:0]  adc;
   } stage_type;

   // Event header latched by a start item.
   typedef struct packed {
      logic [BOARD_W-1:0]    board;
      logic [CAP_WORD_W-1:0] cap_word;
      logic [RAW_W-1:0]      raw_bytes;
   } event_type;

endpackage

`default_nettype wire

@@ src/zsps_ped_mem.sv @@
// Pedestal and threshold table: one write port, one registered read port.
// Uses entry widths from zsps_pkg.
`default_nettype none

module zsps_ped_mem #(
   parameter int DEPTH  = 1,
   parameter int ADDR_W = 1
) (
   input  wire logic                        clock,
   input  wire logic                        wr_en,
   input  wire logic [ADDR_W-1:0]           wr_addr,
   input  wire zsps_pkg::entry_type         wr_data,
   input  wire logic                        rd_en,
   input  wire logic [ADDR_W-1:0]           rd_addr,
   output      zsps_pkg::entry_type         rd_data
);

   logic [zsps_pkg::ENTRY_W-1:0] mem [DEPTH];
   logic [zsps_pkg::ENTRY_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = zsps_pkg::entry_type'(rd_data_ff);

endmodule

`default_nettype wire

@@ src/zsps_front.sv @@
// Front stage: decodes items, forms table addresses, counts channels and
// latches the event header. Uses types and opcodes from zsps_pkg.
`default_nettype none

module zsps_front #(
   parameter int CHANNELS = zsps_pkg::CHANNELS_DEF,
   parameter int CAPS     = zsps_pkg::CAPS_DEF,
   parameter int BOARDS   = zsps_pkg::BOARDS_DEF,
   parameter int ADDR_W   = 1
) (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     req_valid,
   output      logic                     req_stall,
   input  wire zsps_pkg::req_payload_type req_payload,
   input  wire logic                     take,
   output      logic                     mem_wr_en,
   output      logic [ADDR_W-1:0]        mem_wr_addr,
   output      zsps_pkg::entry_type      mem_wr_data,
   output      logic                     mem_rd_en,
   output      logic [ADDR_W-1:0]        mem_rd_addr,
   output      zsps_pkg::stage_type      stage,
   output      zsps_pkg::event_type      evt
);

   localparam int CNT_W = $clog2(CHANNELS + 1);

   zsps_pkg::stage_type stage_ff, stage_in;
   zsps_pkg::event_type evt_ff, evt_in;
   logic [CNT_W-1:0]    chan_index_ff, chan_index_in;
   logic [ADDR_W-1:0]   base_ff, base_in;
   logic                base_ok_ff, base_ok_in;

   logic                         accept;
   logic [zsps_pkg::CAP_SEL_W-1:0] cap;
   logic                         board_cap_ok;
   logic [ADDR_W-1:0]            row_base;
   logic                         sample_go;

   assign req_stall = stage_ff.valid && !take;
   assign accept    = req_valid && !req_stall;

   assign cap = req_payload.cap_word[zsps_pkg::CAP_SEL_W-1:0];
   assign board_cap_ok = (4'(req_payload.board) < 4'(BOARDS)) && (8'(cap) < 8'(CAPS));
   assign row_base = (ADDR_W'(req_payload.board) * ADDR_W'(CAPS) + ADDR_W'(cap))
                     * ADDR_W'(CHANNELS);

   assign mem_wr_en   = accept && (req_payload.op == zsps_pkg::OP_LOAD) && board_cap_ok
                        && (14'(req_payload.chan) < 14'(CHANNELS));
   assign mem_wr_addr = row_base + ADDR_W'(req_payload.chan);
   assign mem_wr_data = '{ped: req_payload.ped_fixed, thr: req_payload.threshold};

   assign sample_go   = chan_index_ff < CNT_W'(CHANNELS);
   assign mem_rd_en   = accept && (req_payload.op == zsps_pkg::OP_SAMPLE) && sample_go;
   assign mem_rd_addr = base_ff + ADDR_W'(chan_index_ff);

   always_comb begin
      stage_in      = stage_ff;
      evt_in        = evt_ff;
      chan_index_in = chan_index_ff;
      base_in       = base_ff;
      base_ok_in    = base_ok_ff;
      if (accept) begin
         stage_in.valid = 1'b1;
         stage_in.op    = req_payload.op;
         stage_in.ok    = sample_go && base_ok_ff;
         stage_in.chan  = zsps_pkg::CHAN_W'(chan_index_ff);
         stage_in.adc   = req_payload.adc;
         unique case (req_payload.op)
            zsps_pkg::OP_START: begin
               evt_in.board     = req_payload.board;
               evt_in.cap_word  = req_payload.cap_word;
               evt_in.raw_bytes = req_payload.raw_bytes;
               chan_index_in    = '0;
               base_in          = row_base;
               base_ok_in       = board_cap_ok;
            end
            zsps_pkg::OP_SAMPLE: begin
               if (sample_go) begin
                  chan_index_in = chan_index_ff + CNT_W'(1);
               end
            end
            zsps_pkg::OP_LOAD, zsps_pkg::OP_END: begin
            end
            default: begin
            end
         endcase
      end else if (take) begin
         stage_in.valid = 1'b0;
      end
   end

   // Only the valid flag and the event state are reset; the rest of the
   // stage register simply follows its next value.
   always_ff @(posedge clock) begin
      if (reset) begin
         stage_ff.valid <= 1'b0;
         evt_ff         <= '0;
         chan_index_ff  <= '0;
         base_ff        <= '0;
         base_ok_ff     <= 1'b1;
      end else begin
         stage_ff.valid <= stage_in.valid;
         evt_ff         <= evt_in;
         chan_index_ff  <= chan_index_in;
         base_ff        <= base_in;
         base_ok_ff     <= base_ok_in;
      end
      stage_ff.op   <= stage_in.op;
      stage_ff.ok   <= stage_in.ok;
      stage_ff.chan <= stage_in.chan;
      stage_ff.adc  <= stage_in.adc;
   end

   assign stage = stage_ff;
   assign evt   = evt_ff;

endmodule

`default_nettype wire

@@ src/zsps_back.sv @@
// Back stage: threshold compare, pedestal subtraction, event accumulation
// and the result register. Uses types and constants from zsps_pkg.
`default_nettype none

module zsps_back #(
   parameter int PED_FRAC_BITS = zsps_pkg::PED_FRAC_BITS_DEF
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire zsps_pkg::stage_type           stage,
   input  wire zsps_pkg::entry_type           entry,
   input  wire zsps_pkg::event_type           evt,
   input  wire logic [zsps_pkg::SECTOR_W-1:0] sector_number,
   output      logic                          take,
   output      logic                          rsp_valid,
   input  wire logic                          rsp_stall,
   output      zsps_pkg::rsp_payload_type     rsp_payload
);

   localparam int HALF  = (PED_FRAC_BITS > 0) ? (1 << (PED_FRAC_BITS - 1)) : 0;
   localparam int RND_W = zsps_pkg::SUM_W + 1;

   logic [zsps_pkg::HITS_W-1:0]       hits_ff, hits_in;
   logic signed [zsps_pkg::SUM_W-1:0] sum_ff, sum_in;
   logic                              rsp_valid_ff, rsp_valid_in;
   zsps_pkg::rsp_payload_type         rsp_ff, rsp_in;

   logic                              fire;
   logic                              hit;
   logic [zsps_pkg::PED_R_W-1:0]      ped_round;
   logic signed [zsps_pkg::SUM_W-1:0] adc_scaled;
   logic signed [zsps_pkg::SUM_W-1:0] ped_ext;
   logic signed [RND_W-1:0]           sum_round;
   logic signed [RND_W-1:0]           sum_shift;
   logic [zsps_pkg::SUM_OUT_W-1:0]    adc_sum;
   logic [zsps_pkg::OBYTES_W:0]       obytes;

   assign take = !rsp_valid_ff || !rsp_stall;
   assign fire = stage.valid && take;
   assign hit  = (stage.op == zsps_pkg::OP_SAMPLE) && stage.ok && (stage.adc > entry.thr);

   assign ped_round  = zsps_pkg::PED_R_W'((zsps_pkg::PED_R_W'(entry.ped)
                       + zsps_pkg::PED_R_W'(HALF)) >> PED_FRAC_BITS);
   assign adc_scaled = $signed(zsps_pkg::SUM_W'(stage.adc) << PED_FRAC_BITS);
   assign ped_ext    = $signed(zsps_pkg::SUM_W'(entry.ped));

   // Summary rounding and saturation of the accumulated sum.
   assign sum_round = RND_W'(sum_ff) + $signed(RND_W'(HALF));
   assign sum_shift = sum_round >>> PED_FRAC_BITS;
   always_comb begin
      if (sum_round <= 0) begin
         adc_sum = '0;
      end else if (sum_shift > $signed(RND_W'(zsps_pkg::ADC_SUM_MAX))) begin
         adc_sum = zsps_pkg::ADC_SUM_MAX;
      end else begin
         adc_sum = sum_shift[zsps_pkg::SUM_OUT_W-1:0];
      end
   end

   assign obytes = zsps_pkg::OBYTES_BASE + (zsps_pkg::OBYTES_W + 1)'({hits_ff, 2'b00});

   always_comb begin
      hits_in      = hits_ff;
      sum_in       = sum_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_in       = rsp_ff;
      if (fire) begin
         if (stage.op == zsps_pkg::OP_START) begin
            hits_in = '0;
            sum_in  = '0;
         end else if (hit) begin
            sum_in = sum_ff + adc_scaled - ped_ext;
            if (hits_ff != zsps_pkg::HITS_MAX) begin
               hits_in = hits_ff + zsps_pkg::HITS_W'(1);
            end
         end
      end
      if (take) begin
         rsp_valid_in = fire && (hit || (stage.op == zsps_pkg::OP_END));
         rsp_in       = '0;
         if (hit) begin
            rsp_in.kind      = zsps_pkg::KIND_HIT;
            rsp_in.hit_chan  = stage.chan;
            rsp_in.hit_value = stage.adc - ped_round[zsps_pkg::ADC_W-1:0];
         end else begin
            rsp_in.kind           = zsps_pkg::KIND_SUMMARY;
            rsp_in.event_cap_word = evt.cap_word;
            rsp_in.fiber          = zsps_pkg::FIBER_W'({sector_number, 1'b0})
                                    + zsps_pkg::FIBER_W'(evt.board)
                                    - zsps_pkg::FIBER_OFFSET;
            rsp_in.hit_count      = hits_ff;
            rsp_in.adc_sum        = adc_sum;
            rsp_in.sparse_bytes   = (obytes > zsps_pkg::OBYTES_MAX)
                                    ? zsps_pkg::OBYTES_W'(zsps_pkg::OBYTES_MAX)
                                    : obytes[zsps_pkg::OBYTES_W-1:0];
            rsp_in.oversize       = zsps_pkg::RAW_W'(obytes) > evt.raw_bytes;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hits_ff      <= '0;
         sum_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         hits_ff      <= hits_in;
         sum_ff       <= sum_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

endmodule

`default_nettype wire

@@ src/zero_suppress_pedestal_subtract_top.sv @@
// Top level of the zero suppression and pedestal subtraction block.
// Instantiates zsps_front, zsps_ped_mem and zsps_back; uses zsps_pkg.
`default_nettype none

// The block suppresses ADC samples that do not exceed a per-channel threshold
// and subtracts a rounded pedestal from those that remain. Load transfers fill
// a table holding one pedestal (unsigned fixed point with PED_FRAC_BITS
// fraction bits) and one threshold for each board, capacitor and channel; an
// entry must be loaded before any sample reads it, and the table has no reset
// and needs no clearing pass. A start transfer opens an event for one board
// and the capacitor in the low seven bits of its capacitor word, records the
// raw byte count and clears the event counters. Each sample transfer after it
// takes the next channel number; a sample above its threshold produces a hit
// record, and samples beyond CHANNELS in one event are dropped. An end
// transfer produces a summary with the hit count, the fiber (derived from the
// sector register and the board), the output byte count with its oversize
// flag, and the rounded, saturated ADC sum. An end does not close the event,
// so a second end repeats the summary. Every transfer is accepted at one per
// clock unless the input stalls: the front stage forms the table address and
// issues the read while it loads the stage register, and the back stage then
// compares, subtracts, accumulates and loads the result register, from which
// the result is offered. The single table read port per sample sets that rate.
// The input stalls only while the front stage register holds an item that
// cannot move into an occupied, stalled result register. The sector register
// must be written only while the block is idle; the block does not enforce it.
module zero_suppress_pedestal_subtract_top #(
   parameter int CHANNELS      = zsps_pkg::CHANNELS_DEF,
   parameter int CAPS          = zsps_pkg::CAPS_DEF,
   parameter int BOARDS        = zsps_pkg::BOARDS_DEF,
   parameter int PED_FRAC_BITS = zsps_pkg::PED_FRAC_BITS_DEF
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          req_valid,
   output      logic                          req_stall,
   input  wire zsps_pkg::req_payload_type     req_payload,
   output      logic                          rsp_valid,
   input  wire logic                          rsp_stall,
   output      zsps_pkg::rsp_payload_type     rsp_payload,
   input  wire logic                          csr_write_enable,
   input  wire logic [zsps_pkg::SECTOR_W-1:0] csr_write_data
);

   // Table depth and address width follow from the geometry.
   localparam int DEPTH  = BOARDS * CAPS * CHANNELS;
   localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

   logic [zsps_pkg::SECTOR_W-1:0] sector_number_ff, sector_number_in;

   logic                take;
   logic                mem_wr_en;
   logic [ADDR_W-1:0]   mem_wr_addr;
   zsps_pkg::entry_type mem_wr_data;
   logic                mem_rd_en;
   logic [ADDR_W-1:0]   mem_rd_addr;
   zsps_pkg::entry_type mem_rd_data;
   zsps_pkg::stage_type stage;
   zsps_pkg::event_type evt;

   // Sector register; one transfer on the configuration port replaces it.
   assign sector_number_in = csr_write_enable ? csr_write_data : sector_number_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         sector_number_ff <= zsps_pkg::SECTOR_RESET;
      end else begin
         sector_number_ff <= sector_number_in;
      end
   end

   // Front stage: decode, channel counting and table addressing.
   zsps_front #(
      .CHANNELS (CHANNELS),
      .CAPS     (CAPS),
      .BOARDS   (BOARDS),
      .ADDR_W   (ADDR_W)
   ) u_front (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_payload (req_payload),
      .take        (take),
      .mem_wr_en   (mem_wr_en),
      .mem_wr_addr (mem_wr_addr),
      .mem_wr_data (mem_wr_data),
      .mem_rd_en   (mem_rd_en),
      .mem_rd_addr (mem_rd_addr),
      .stage       (stage),
      .evt         (evt)
   );

   // Pedestal and threshold table; its registered read lines up with the
   // front stage register.
   zsps_ped_mem #(
      .DEPTH  (DEPTH),
      .ADDR_W (ADDR_W)
   ) u_ped_mem (
      .clock   (clock),
      .wr_en   (mem_wr_en),
      .wr_addr (mem_wr_addr),
      .wr_data (mem_wr_data),
      .rd_en   (mem_rd_en),
      .rd_addr (mem_rd_addr),
      .rd_data (mem_rd_data)
   );

   // Back stage: compare, subtract, accumulate and hold the result.
   zsps_back #(
      .PED_FRAC_BITS (PED_FRAC_BITS)
   ) u_back (
      .clock         (clock),
      .reset         (reset),
      .stage         (stage),
      .entry         (mem_rd_data),
      .evt           (evt),
      .sector_number (sector_number_ff),
      .take          (take),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_payload   (rsp_payload)
   );

endmodule

`default_nettype wire

@@ verif/tb.sv @@
// Self-checking testbench for zero_suppress_pedestal_subtract_top.
// Predicts hit records and event summaries from the transfers it sends and checks them.
// Depends on zsps_pkg and the block's RTL only.
`timescale 1ns / 1ps

module tb;

   // Timing of the run. A result passes the stage and result registers after its
   // input transfer, so SETTLE_CYCLES quiet cycles let the pipeline drain.
   localparam int IDLE_PERCENT        = 23;
   localparam int SETTLE_CYCLES       = 6;
   localparam int HOLD_OFF_CYCLES     = 150;
   localparam int RANDOM_ITEMS        = 850;
   localparam int STEADY_ITEMS        = 250;
   localparam int SECTOR_INTERVAL     = 300;
   localparam int LONG_EVENT_CHANNELS = 120;
   localparam int TIME_LIMIT_NS       = 5_000_000;

   // Rounding offset of the pedestal: one half in the pedestal's fixed point.
   localparam int PED_HALF = (zsps_pkg::PED_FRAC_BITS_DEF > 0) ?
                             (1 << ((zsps_pkg::PED_FRAC_BITS_DEF > 0) ?
                                    zsps_pkg::PED_FRAC_BITS_DEF - 1 : 0)) : 0;
   localparam int BOARD_CODE_MAX = (1 << zsps_pkg::BOARD_W) - 1;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic                                req_valid        = 1'b0;
   logic                                req_stall;
   zsps_pkg::req_payload_type           req_payload      = '0;
   logic                                rsp_valid;
   logic                                rsp_stall        = 1'b0;
   zsps_pkg::rsp_payload_type           rsp_payload;
   logic                                csr_write_enable = 1'b0;
   logic [zsps_pkg::SECTOR_W-1:0]       csr_write_data   = '0;

   // Shared flags between the stimulus and the receiver. While steady_flow is
   // set neither side idles; hold_off_request asks the receiver for one long
   // stall, which it counts down itself.
   bit steady_flow      = 1'b0;
   bit hold_off_request = 1'b0;
   int hold_off_left    = 0;

   // Predicted state of the block: the pedestal and threshold table, the
   // open event and the sector register.
   zsps_pkg::entry_type             ped_table [int unsigned];
   logic [zsps_pkg::SECTOR_W-1:0]   sector_reg   = zsps_pkg::SECTOR_RESET;
   logic [zsps_pkg::BOARD_W-1:0]    ev_board     = '0;
   logic [zsps_pkg::CAP_WORD_W-1:0] ev_cap_word  = '0;
   logic [zsps_pkg::RAW_W-1:0]      ev_raw_bytes = '0;
   int                              ev_chan      = 0;
   logic [zsps_pkg::HITS_W-1:0]     ev_hits      = '0;
   longint                          ev_sum       = 0;

   // Results predicted but not yet seen on the output, oldest first.
   zsps_pkg::rsp_payload_type pending_records [$];

   int error_count         = 0;
   int transfers_in        = 0;
   int effective_transfers = 0;
   int hit_records_seen    = 0;
   int summaries_seen      = 0;
   int input_stall_cycles  = 0;

   zero_suppress_pedestal_subtract_top u_dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_payload      (req_payload),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_payload      (rsp_payload),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Address of one table entry; returns 0 when the location lies outside the
   // table, in which case a load is dropped and a sample is never kept.
   function automatic bit table_index(input logic [zsps_pkg::BOARD_W-1:0] board,
                                      input logic [zsps_pkg::CAP_WORD_W-1:0] cap_word,
                                      input int chan, output int unsigned loc);
      loc = 0;
      if (int'(board) >= zsps_pkg::BOARDS_DEF || chan >= zsps_pkg::CHANNELS_DEF) begin
         return 1'b0;
      end
      loc = (int'(board) * zsps_pkg::CAPS_DEF + int'(cap_word[zsps_pkg::CAP_SEL_W-1:0]))
            * zsps_pkg::CHANNELS_DEF + chan;
      return 1'b1;
   endfunction

   // Updates the predicted state for one accepted transfer and queues the
   // hit record or summary that it causes.
   task automatic predict_zero_suppress(input zsps_pkg::req_payload_type item);
      zsps_pkg::rsp_payload_type rec;
      int unsigned               loc;
      int                        ch;
      int                        ped_round;
      int                        diff;
      int                        fib;
      int                        total;
      longint                    acc;
      bit                        ignored;
      rec     = '0;
      ignored = 1'b0;
      case (item.op)
         zsps_pkg::OP_LOAD: begin
            if (table_index(item.board, item.cap_word, int'(item.chan), loc)) begin
               ped_table[loc] = '{ped: item.ped_fixed, thr: item.threshold};
            end else begin
               ignored = 1'b1;
            end
         end
         zsps_pkg::OP_START: begin
            ev_board     = item.board;
            ev_cap_word  = item.cap_word;
            ev_raw_bytes = item.raw_bytes;
            ev_chan      = 0;
            ev_hits      = '0;
            ev_sum       = 0;
         end
         zsps_pkg::OP_SAMPLE: begin
            if (ev_chan >= zsps_pkg::CHANNELS_DEF) begin
               ignored = 1'b1;
            end else begin
               ch      = ev_chan;
               ev_chan = ev_chan + 1;
               // Only a sample strictly above its threshold is kept.
               if (table_index(ev_board, ev_cap_word, ch, loc) &&
                   item.adc > ped_table[loc].thr) begin
                  ped_round = (int'(ped_table[loc].ped) + PED_HALF)
                              >> zsps_pkg::PED_FRAC_BITS_DEF;
                  diff      = int'(item.adc) - ped_round;
                  ev_sum    = ev_sum + (longint'(item.adc) <<< zsps_pkg::PED_FRAC_BITS_DEF)
                              - longint'(ped_table[loc].ped);
                  if (ev_hits < zsps_pkg::HITS_MAX) begin
                     ev_hits = ev_hits + 1'b1;
                  end
                  rec.kind      = zsps_pkg::KIND_HIT;
                  rec.hit_chan  = zsps_pkg::CHAN_W'(ch);
                  rec.hit_value = zsps_pkg::ADC_W'(diff);
                  pending_records.push_back(rec);
               end
            end
         end
         default: begin
            // End of event: the sum is rounded like the pedestal and clipped
            // to the output range; the event itself stays open.
            total = int'(zsps_pkg::OBYTES_BASE) + 4 * int'(ev_hits);
            acc   = ev_sum + PED_HALF;
            fib   = 2 * int'(sector_reg) - int'(zsps_pkg::FIBER_OFFSET) + int'(ev_board);
            rec.kind           = zsps_pkg::KIND_SUMMARY;
            rec.event_cap_word = ev_cap_word;
            rec.fiber          = zsps_pkg::FIBER_W'(fib);
            rec.hit_count      = ev_hits;
            if (acc <= 0) begin
               rec.adc_sum = '0;
            end else if ((acc >>> zsps_pkg::PED_FRAC_BITS_DEF)
                         > longint'(zsps_pkg::ADC_SUM_MAX)) begin
               rec.adc_sum = zsps_pkg::ADC_SUM_MAX;
            end else begin
               rec.adc_sum = zsps_pkg::SUM_OUT_W'(acc >>> zsps_pkg::PED_FRAC_BITS_DEF);
            end
            rec.sparse_bytes = (total > int'(zsps_pkg::OBYTES_MAX))
                               ? zsps_pkg::OBYTES_W'(zsps_pkg::OBYTES_MAX)
                               : zsps_pkg::OBYTES_W'(total);
            rec.oversize     = total > int'(ev_raw_bytes);
            pending_records.push_back(rec);
         end
      endcase
      if (!ignored) begin
         effective_transfers++;
      end
   endtask

   // Every field starts random so that the fields an operation does not use
   // also see both values on every bit.
   function automatic zsps_pkg::req_payload_type random_item(input zsps_pkg::op_type op);
      logic [127:0]              bits;
      zsps_pkg::req_payload_type item;
      bits    = {$urandom(), $urandom(), $urandom(), $urandom()};
      item    = bits[$bits(zsps_pkg::req_payload_type)-1:0];
      item.op = op;
      return item;
   endfunction

   function automatic zsps_pkg::entry_type random_entry();
      zsps_pkg::entry_type ent;
      case ($urandom_range(7))
         0:       ent.thr = '0;
         1:       ent.thr = '1;
         2, 3:    ent.thr = zsps_pkg::THR_W'($urandom_range(0, 16'h0FFF));
         default: ent.thr = zsps_pkg::THR_W'($urandom());
      endcase
      case ($urandom_range(5))
         0:       ent.ped = '0;
         1:       ent.ped = '1;
         2, 3:    ent.ped = zsps_pkg::PED_W'($urandom_range(0, 20'h0FFFF));
         default: ent.ped = zsps_pkg::PED_W'($urandom());
      endcase
      return ent;
   endfunction

   function automatic logic [zsps_pkg::ADC_W-1:0] random_adc();
      case ($urandom_range(11))
         0:       return '0;
         1:       return '1;
         default: return zsps_pkg::ADC_W'($urandom());
      endcase
   endfunction

   // Offers one transfer, with a random idle gap in front of it unless steady_flow
   // is set, and returns at the clock edge that accepts it. Valid is left high;
   // the next call lowers it only for an idle gap, and a drain lowers it.
   task automatic send_item(input zsps_pkg::req_payload_type item);
      if (!steady_flow && $urandom_range(99) < IDLE_PERCENT) begin
         req_valid <= 1'b0;
         @(posedge clock);
         while ($urandom_range(99) < IDLE_PERCENT) begin
            @(posedge clock);
         end
      end
      req_valid   <= 1'b1;
      req_payload <= item;
      // Decide at the falling edge, where every signal has settled, whether
      // the next rising edge takes the transfer.
      @(negedge clock);
      while (req_stall) begin
         @(negedge clock);
      end
      @(posedge clock);
      transfers_in++;
      predict_zero_suppress(item);
   endtask

   task automatic send_load(input logic [zsps_pkg::BOARD_W-1:0] board,
                            input logic [zsps_pkg::CAP_WORD_W-1:0] cap_word,
                            input int chan, input zsps_pkg::entry_type ent);
      zsps_pkg::req_payload_type item;
      item           = random_item(zsps_pkg::OP_LOAD);
      item.board     = board;
      item.cap_word  = cap_word;
      item.chan      = zsps_pkg::CHAN_W'(chan);
      item.ped_fixed = ent.ped;
      item.threshold = ent.thr;
      send_item(item);
   endtask

   task automatic send_start(input logic [zsps_pkg::BOARD_W-1:0] board,
                             input logic [zsps_pkg::CAP_WORD_W-1:0] cap_word,
                             input logic [zsps_pkg::RAW_W-1:0] raw_bytes);
      zsps_pkg::req_payload_type item;
      item           = random_item(zsps_pkg::OP_START);
      item.board     = board;
      item.cap_word  = cap_word;
      item.raw_bytes = raw_bytes;
      send_item(item);
   endtask

   // A sample reads the entry of the next channel, so that entry is loaded
   // first whenever the table has never seen it.
   task automatic send_sample(input logic [zsps_pkg::ADC_W-1:0] adc);
      zsps_pkg::req_payload_type item;
      int unsigned               loc;
      if (table_index(ev_board, ev_cap_word, ev_chan, loc) && !ped_table.exists(loc)) begin
         send_load(ev_board, ev_cap_word, ev_chan, random_entry());
      end
      item     = random_item(zsps_pkg::OP_SAMPLE);
      item.adc = adc;
      send_item(item);
   endtask

   task automatic send_end();
      send_item(random_item(zsps_pkg::OP_END));
   endtask

   // Lowers valid and waits until every predicted result has been taken and
   // the pipeline has had time to finish transfers that produce nothing.
   task automatic wait_for_drain();
      req_valid <= 1'b0;
      while (pending_records.size() != 0) begin
         @(posedge clock);
      end
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_sector(input logic [zsps_pkg::SECTOR_W-1:0] value);
      wait_for_drain();
      csr_write_enable <= 1'b1;
      csr_write_data   <= value;
      @(posedge clock);
      csr_write_enable <= 1'b0;
      sector_reg = value;
   endtask

   // Right after reset, with no start: the event state is all zero, so the
   // first summary is empty and samples use board 0, capacitor 0.
   task automatic test_no_start_after_reset();
      send_end();
      // Capacitor word with high bits set still selects capacitor 0.
      send_load(0, 16'hFF80, 0, '{ped: 20'h00010, thr: 16'h0000});
      send_load(0, 16'hFF80, 1, '{ped: 20'h00000, thr: 16'h0100});
      send_load(0, 16'hFF80, 2, '{ped: 20'h00018, thr: 16'h0100});
      send_sample(16'h0005);
      send_sample(16'h0100);   // equal to the threshold: dropped
      send_sample(16'h0101);   // one above: kept
      send_end();
   endtask

   // Field extremes on the last board and capacitor, rounding of the
   // pedestal both ways, a repeated end and a sum that goes negative.
   task automatic test_field_extremes();
      write_sector(zsps_pkg::SECTOR_W'(15));
      send_load(5, 16'hFFFF, 0, '{ped: 20'h00000, thr: 16'h0000});
      send_load(5, 16'hFFFF, 1, '{ped: 20'hFFFFF, thr: 16'hFFFE});
      send_load(5, 16'hFFFF, 2, '{ped: 20'h12345, thr: 16'hFFFF});
      send_load(5, 16'hFFFF, 3, '{ped: 20'h00008, thr: 16'h0000});
      send_load(5, 16'hFFFF, 4, '{ped: 20'h00007, thr: 16'h0000});
      send_start(5, 16'hFFFF, 20'hFFFFF);
      send_sample(16'h0000);
      send_sample(16'hFFFF);   // pedestal rounds past the sample: value wraps
      send_sample(16'hFFFF);   // threshold at the top: never kept
      send_sample(16'h0001);
      send_sample(16'h0001);
      send_end();
      send_end();              // the event stays open, so the summary repeats
      send_sample(random_adc());
      send_end();
      send_start(2, 16'h5A03, 20'h00000);
      send_load(2, 16'h5A03, 0, '{ped: 20'hFFFFF, thr: 16'h0000});
      send_sample(16'h0005);   // sum below zero clips to zero
      send_end();
   endtask

   // Loads outside the table, events on boards that do not exist, and the
   // sector register at zero, where the fiber number wraps.
   task automatic test_out_of_range_and_sector();
      send_load(6, 16'h0001, 0, random_entry());
      send_load(7, 16'h0001, 0, random_entry());
      send_load(0, 16'h0001, zsps_pkg::CHANNELS_DEF, random_entry());
      send_load(0, 16'h0001, (1 << zsps_pkg::CHAN_W) - 1, random_entry());
      send_start(6, 16'h0001, 20'h00010);
      send_sample(16'hFFFF);
      send_sample(16'h8000);
      send_end();
      write_sector('0);
      send_end();
      send_start(7, 16'hABCD, 20'h00007);
      send_sample(16'h1234);
      send_end();
      send_start(0, 16'h0000, 20'h00008);
      send_end();
      write_sector(zsps_pkg::SECTOR_RESET);
   endtask

   // One long event over many channels of one board and capacitor, with a
   // sparse pattern of channels whose threshold lets every nonzero sample through.
   task automatic test_long_event();
      int k;
      for (k = 0; k < LONG_EVENT_CHANNELS; k++) begin
         send_load(1, 16'h0042, k,
                   '{ped: zsps_pkg::PED_W'($urandom()),
                     thr: (k % 7 == 0) ? 16'h0000 : 16'hFFFF});
      end
      send_start(1, 16'h0042, 20'd100);
      for (k = 0; k < LONG_EVENT_CHANNELS; k++) begin
         send_sample(random_adc());
      end
      send_end();
   endtask

   // The receiver stalls for a long stretch while every sample makes a hit,
   // so the block fills up and has to stall its input.
   task automatic test_backpressure();
      int k;
      for (k = 0; k < 40; k++) begin
         send_load(3, 16'h1205, k,
                   '{ped: zsps_pkg::PED_W'($urandom_range(0, 20'h00FFF)), thr: '0});
      end
      send_start(3, 16'h1205, 20'd64);
      hold_off_request = 1'b1;
      for (k = 0; k < 40; k++) begin
         send_sample(zsps_pkg::ADC_W'($urandom_range(1, 16'hFFFF)));
      end
      send_end();
   endtask

   // Mostly well-formed events with random content and size, mixed with
   // stray transfers: missing starts, repeated ends, samples after an end,
   // loads outside the table. The first stretch runs with no idling.
   task automatic test_random_traffic();
      int                              stop_at;
      int                              steady_until;
      int                              next_sector;
      int                              n;
      int                              k;
      logic [zsps_pkg::BOARD_W-1:0]    board;
      logic [zsps_pkg::CAP_WORD_W-1:0] cap_word;
      logic [zsps_pkg::RAW_W-1:0]      raw_bytes;
      stop_at      = effective_transfers + RANDOM_ITEMS;
      steady_until = effective_transfers + STEADY_ITEMS;
      next_sector  = effective_transfers + SECTOR_INTERVAL;
      steady_flow  = 1'b1;
      while (effective_transfers < stop_at) begin
         if (steady_flow && effective_transfers >= steady_until) begin
            steady_flow = 1'b0;
         end
         if (effective_transfers >= next_sector) begin
            write_sector(zsps_pkg::SECTOR_W'($urandom_range(0, (1 << zsps_pkg::SECTOR_W) - 1)));
            next_sector = next_sector + SECTOR_INTERVAL;
         end
         if ($urandom_range(99) < 80) begin
            if ($urandom_range(9) == 0) begin
               board = zsps_pkg::BOARD_W'($urandom_range(zsps_pkg::BOARDS_DEF,
                                                         BOARD_CODE_MAX));
            end else begin
               board = zsps_pkg::BOARD_W'($urandom_range(0, zsps_pkg::BOARDS_DEF - 1));
            end
            cap_word  = zsps_pkg::CAP_WORD_W'($urandom());
            raw_bytes = $urandom_range(1) ? zsps_pkg::RAW_W'($urandom_range(0, 64))
                                          : zsps_pkg::RAW_W'($urandom());
            n         = $urandom_range(0, 12);
            if (int'(board) < zsps_pkg::BOARDS_DEF) begin
               for (k = 0; k < n; k++) begin
                  send_load(board, cap_word, k, random_entry());
               end
            end
            if ($urandom_range(9) != 0) begin
               send_start(board, cap_word, raw_bytes);
            end
            for (k = 0; k < n; k++) begin
               send_sample(random_adc());
            end
            send_end();
            if ($urandom_range(6) == 0) begin
               send_end();
            end
            if ($urandom_range(9) == 0) begin
               send_sample(random_adc());
               send_end();
            end
         end else begin
            case ($urandom_range(3))
               0: send_load(zsps_pkg::BOARD_W'($urandom_range(0, BOARD_CODE_MAX)),
                            zsps_pkg::CAP_WORD_W'($urandom()),
                            $urandom_range(0, (1 << zsps_pkg::CHAN_W) - 1), random_entry());
               1: send_start(zsps_pkg::BOARD_W'($urandom_range(0, BOARD_CODE_MAX)),
                             zsps_pkg::CAP_WORD_W'($urandom()),
                             zsps_pkg::RAW_W'($urandom()));
               2: send_sample(random_adc());
               default: send_end();
            endcase
         end
      end
      steady_flow = 1'b0;
   endtask

   // Receiver: stalls at random, not at all during the steady stretch, and
   // for one long stretch when the back-pressure test asks for it.
   always @(posedge clock) begin
      if (hold_off_request) begin
         hold_off_request = 1'b0;
         hold_off_left    = HOLD_OFF_CYCLES;
      end
      if (reset) begin
         rsp_stall <= 1'b0;
      end else if (hold_off_left > 0) begin
         rsp_stall <= 1'b1;
         hold_off_left--;
      end else begin
         rsp_stall <= !steady_flow && ($urandom_range(99) < IDLE_PERCENT);
      end
   end

   // Checks each result transfer against the oldest prediction. Signals are
   // read at the falling edge; a result seen there with stall low is taken
   // at the next rising edge.
   always @(negedge clock) begin : result_checker
      zsps_pkg::rsp_payload_type want;
      if (!reset) begin
         if (req_valid && req_stall) begin
            input_stall_cycles++;
         end
         if (rsp_valid && !rsp_stall) begin
            if (pending_records.size() == 0) begin
               $error("unexpected result transfer, kind %0d", rsp_payload.kind);
               error_count++;
            end else begin
               want = pending_records.pop_front();
               if (want.kind == zsps_pkg::KIND_HIT) begin
                  hit_records_seen++;
               end else begin
                  summaries_seen++;
               end
               if (rsp_payload.kind !== want.kind) begin
                  $error("kind: expected %0d, got %0d", want.kind, rsp_payload.kind);
                  error_count++;
               end
               if (rsp_payload.hit_chan !== want.hit_chan) begin
                  $error("hit_chan: expected %0d, got %0d", want.hit_chan, rsp_payload.hit_chan);
                  error_count++;
               end
               if (rsp_payload.hit_value !== want.hit_value) begin
                  $error("hit_value: expected %0h, got %0h", want.hit_value,
                         rsp_payload.hit_value);
                  error_count++;
               end
               if (rsp_payload.event_cap_word !== want.event_cap_word) begin
                  $error("event_cap_word: expected %0h, got %0h", want.event_cap_word,
                         rsp_payload.event_cap_word);
                  error_count++;
               end
               if (rsp_payload.fiber !== want.fiber) begin
                  $error("fiber: expected %0d, got %0d", want.fiber, rsp_payload.fiber);
                  error_count++;
               end
               if (rsp_payload.hit_count !== want.hit_count) begin
                  $error("hit_count: expected %0d, got %0d", want.hit_count,
                         rsp_payload.hit_count);
                  error_count++;
               end
               if (rsp_payload.adc_sum !== want.adc_sum) begin
                  $error("adc_sum: expected %0d, got %0d", want.adc_sum, rsp_payload.adc_sum);
                  error_count++;
               end
               if (rsp_payload.sparse_bytes !== want.sparse_bytes) begin
                  $error("sparse_bytes: expected %0d, got %0d", want.sparse_bytes,
                         rsp_payload.sparse_bytes);
                  error_count++;
               end
               if (rsp_payload.oversize !== want.oversize) begin
                  $error("oversize: expected %0d, got %0d", want.oversize, rsp_payload.oversize);
                  error_count++;
               end
            end
         end
      end
   end

   // Main sequence: one reset, the directed tests, the random traffic, then
   // a full drain before the verdict.
   initial begin
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      test_no_start_after_reset();
      test_field_extremes();
      test_out_of_range_and_sector();
      test_long_event();
      test_backpressure();
      test_random_traffic();
      wait_for_drain();
      $display("tb: %0d transfers in (%0d not ignored), %0d table entries loaded",
               transfers_in, effective_transfers, ped_table.num());
      $display("tb: %0d hit records and %0d summaries checked, input stalled %0d cycles",
               hit_records_seen, summaries_seen, input_stall_cycles);
      if (error_count == 0) begin
         $display("tb: PASS");
      end else begin
         $display("tb: FAIL");
      end
      $finish;
   end

   // Watchdog for a block that hangs or loses results.
   initial begin
      #(TIME_LIMIT_NS);
      $display("tb: FAIL");
      $finish;
   end

endmodule
